// File: sv/ip_address_text_validator_macros.svh
// Assertion macros shared by the address text validator RTL.
`ifndef IP_ADDRESS_TEXT_VALIDATOR_MACROS_SVH
`define IP_ADDRESS_TEXT_VALIDATOR_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define IPATV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define IPATV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/ipatv_pkg.sv
// Package: constants and types of the IPv4/IPv6 address text validator.
package ipatv_pkg;

    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned CNT_W       = 6;

    localparam logic [CNT_W-1:0] V4_MAX_LEN = 6'd15;
    localparam logic [CNT_W-1:0] V6_MAX_LEN = 6'd39;
    localparam logic [CNT_W-1:0] CNT_SAT    = 6'd40;

    localparam logic [9:0] OCTET_MAX = 10'd255;
    localparam logic [7:0] MCAST_LO  = 8'd224;
    localparam logic [7:0] MCAST_HI  = 8'd239;

    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;

    // running parse state
    typedef struct packed {
        logic [CNT_W-1:0] char_count;
        logic             v4_ok;
        logic [2:0]       v4_octets;
        logic [1:0]       v4_digits;
        logic [9:0]       v4_value;
        logic             v4_lead_zero;
        logic [7:0]       v4_first;
        logic             v6_ok;
        logic [2:0]       v6_digits;
        logic [3:0]       v6_groups;
        logic [1:0]       v6_run;
        logic             v6_run_start;
        logic             v6_compress;
    } t_parse;

    localparam t_parse PARSE_RESET = '{
        char_count:   '0,
        v4_ok:        1'b1,
        v4_octets:    '0,
        v4_digits:    '0,
        v4_value:     '0,
        v4_lead_zero: 1'b0,
        v4_first:     '0,
        v6_ok:        1'b1,
        v6_digits:    '0,
        v6_groups:    '0,
        v6_run:       '0,
        v6_run_start: 1'b0,
        v6_compress:  1'b0
    };

    // verdict, lowest bit first: valid_ipv4, valid_ipv6, valid_any, multicast_v4
    typedef struct packed {
        logic multicast_v4;
        logic valid_any;
        logic valid_ipv6;
        logic valid_ipv4;
    } t_verdict;

endpackage

// File: sv/ip_address_text_validator.sv
// Top level: streaming IPv4/IPv6 address text validator.
//
// Usage:
// - Slave stream: one ASCII character per transfer in s_axis_tdata, s_axis_tlast
//   on the final character of the address string.
// - Master stream: one verdict transfer per string, produced for the transfer
//   carrying tlast. Non-last characters produce nothing on the master side.
// - Throughput: one character per cycle, sustained, as long as verdicts are
//   taken. Every character passes an input register, then one pass of small
//   parse logic updates the running state (and on tlast the verdict register).
// - Verdict path: a last character passes the input register, then waits there
//   until the verdict register is free or being taken; that register drives m_axis_tvalid.
// - Stall: a waiting verdict does not block input; one more string's
//   characters keep flowing until its own last character sits in the input
//   register with the verdict register still full, then s_axis_tready drops.
// - Reset (i_rst_n low, synchronous): both stages empty, parse state back to
//   its start values. After each verdict the parse state also restarts, so
//   strings follow back to back.
`include "ip_address_text_validator_macros.svh"

module ip_address_text_validator
    import ipatv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // slave stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [CHAR_W-1:0] s_axis_tdata,   // [7:0] ascii_char
    input  logic              s_axis_tlast,   // is_last
    // master stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata    // [0] valid_ipv4, [1] valid_ipv6,
                                              // [2] valid_any, [3] multicast_v4,
                                              // [7:4] zero
);

    // input register
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_last;

    // parse state and verdict register
    t_parse   r_st, n_st;
    logic     r_out_valid;
    t_verdict r_out, n_out;

    logic advance;   // input register item is consumed this cycle

    // a last character may only move on when the verdict slot frees up
    assign advance       = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // parse one character
    always_comb begin
        t_parse            s;
        logic              is_dec;
        logic              is_hex;
        logic [3:0]        dig;
        logic [13:0]       prod;
        logic [3:0]        groups_fin;
        logic              v4;
        logic              v6;
        logic              v6_ok_fin;

        s      = r_st;
        is_dec = r_in_char inside {[CHAR_0:CHAR_9]};
        is_hex = r_in_char inside {[CHAR_0:CHAR_9], [CHAR_LA:CHAR_LF], [CHAR_UA:CHAR_UF]};
        dig    = r_in_char[3:0];
        prod   = 14'(r_st.v4_value) * 14'd10 + 14'(dig);

        // length, saturating just past the IPv6 limit
        if (s.char_count < CNT_SAT) begin
            s.char_count = s.char_count + 6'd1;
        end
        if (s.char_count > V4_MAX_LEN) s.v4_ok = 1'b0;
        if (s.char_count > V6_MAX_LEN) s.v6_ok = 1'b0;

        // IPv4 dotted quad
        if (is_dec) begin
            if (s.v4_digits == 2'd3) begin
                s.v4_ok = 1'b0;
            end else if (s.v4_digits != 2'd0 && s.v4_lead_zero) begin
                s.v4_ok = 1'b0;
            end else begin
                if (s.v4_digits == 2'd0) s.v4_lead_zero = (dig == 4'd0);
                s.v4_value  = prod[9:0];
                s.v4_digits = s.v4_digits + 2'd1;
                if (prod[9:0] > OCTET_MAX) s.v4_ok = 1'b0;
            end
        end else if (r_in_char == CHAR_DOT) begin
            if (s.v4_digits == 2'd0 || s.v4_octets >= 3'd3) begin
                s.v4_ok = 1'b0;
            end else begin
                if (s.v4_octets == 3'd0) s.v4_first = s.v4_value[7:0];
                s.v4_octets    = s.v4_octets + 3'd1;
                s.v4_digits    = '0;
                s.v4_value     = '0;
                s.v4_lead_zero = 1'b0;
            end
        end else begin
            s.v4_ok = 1'b0;
        end

        // IPv6 groups and colon runs
        if (is_hex) begin
            // a single leading colon followed by a digit
            if (s.v6_run_start && s.v6_run == 2'd1) s.v6_ok = 1'b0;
            s.v6_run       = '0;
            s.v6_run_start = 1'b0;
            if (s.v6_digits < 3'd5) s.v6_digits = s.v6_digits + 3'd1;
            if (s.v6_digits > 3'd4) s.v6_ok = 1'b0;
        end else if (r_in_char == CHAR_COLON) begin
            if (s.v6_digits != 3'd0 && s.v6_groups != 4'd15) begin
                s.v6_groups = s.v6_groups + 4'd1;
            end
            s.v6_digits = '0;
            if (s.char_count == 6'd1) s.v6_run_start = 1'b1;
            if (s.v6_run != 2'd3) s.v6_run = s.v6_run + 2'd1;
            if (s.v6_run == 2'd2) begin
                if (s.v6_compress) s.v6_ok = 1'b0;
                s.v6_compress = 1'b1;
            end else if (s.v6_run == 2'd3) begin
                s.v6_ok = 1'b0;
            end
        end else begin
            s.v6_ok = 1'b0;
        end

        // verdict on the last character
        v4 = s.v4_ok && s.v4_octets == 3'd3 && s.v4_digits != 2'd0;

        v6_ok_fin  = s.v6_ok && (s.v6_run != 2'd1);   // no trailing lone colon
        groups_fin = (s.v6_digits != 3'd0 && s.v6_groups != 4'd15) ?
                     s.v6_groups + 4'd1 : s.v6_groups;
        v6 = v6_ok_fin && (s.v6_compress ? (groups_fin <= 4'd7) : (groups_fin == 4'd8));

        n_out.valid_ipv4   = v4;
        n_out.valid_ipv6   = v6;
        n_out.valid_any    = v4 || v6;
        n_out.multicast_v4 = v4 && (s.v4_first inside {[MCAST_LO:MCAST_HI]});

        n_st = r_in_last ? PARSE_RESET : s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= PARSE_RESET;
        end else if (advance) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= n_out;
        end
    end

    `IPATV_ASSERT_NOW(a_mcast_is_v4, r_out_valid && r_out.multicast_v4,
        r_out.valid_ipv4 && r_out.valid_any, "multicast verdict without valid IPv4")
    `IPATV_ASSERT_NOW(a_count_sat, 1'b1, r_st.char_count <= CNT_SAT,
        "character count beyond saturation")
    `IPATV_ASSERT_NEXT(a_restart, advance && r_in_last,
        r_st.char_count == '0 && r_out_valid, "parse state not restarted after verdict")
    `IPATV_ASSERT_NOW(a_stall_cause, !s_axis_tready,
        r_in_valid && r_in_last && r_out_valid && !m_axis_tready,
        "input stalled without a blocked verdict")
    `IPATV_ASSERT_NEXT(a_hold_state, r_in_valid && !advance, $stable(r_st),
        "parse state moved while input was blocked")

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the streaming IPv4/IPv6 address text validator.
`timescale 1ns / 1ps

module testbench
    import ipatv_pkg::*;
();

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_CHARS = 1150;
    localparam int CALM_FROM    = 300;    // no idling on either side in this window
    localparam int CALM_TO      = 800;
    localparam int IDLE_PCT     = 25;
    localparam int TAIL_CYCLES  = 4;      // quiet time after the last verdict

    // One character transfer waiting for the driver.
    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_char_xfer;

    // Running parse of the current string, at the block's register widths.
    typedef struct packed {
        logic [5:0] chars;        // saturates at 40
        logic       v4_ok;
        logic [2:0] v4_dots;
        logic [1:0] v4_digits;
        logic [9:0] v4_value;
        logic       v4_lead0;
        logic [7:0] v4_first;     // octet closed by the first dot
        logic       v6_ok;
        logic [2:0] v6_digits;    // saturates at 5
        logic [3:0] v6_groups;    // saturates at 15
        logic [1:0] v6_run;       // colon run, saturates at 3
        logic       v6_run_start; // current run began at the first character
        logic       v6_compress;  // "::" seen
    } t_addr_scan;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = '0;   // [7:0] ascii_char
    logic       s_axis_tlast  = 1'b0; // is_last
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;         // [0] valid_ipv4, [1] valid_ipv6, [2] valid_any,
                                      // [3] multicast_v4, [7:4] zero

    t_char_xfer chars_pending[$];
    t_verdict   verdicts_due[$];
    logic [7:0] text[$];              // string under construction
    t_addr_scan scan;

    logic in_accepted = 1'b0;         // slave transfer at the last rising edge
    int   cycles      = 0;
    int   errors      = 0;
    int   chars_queued   = 0;
    int   chars_accepted = 0;
    int   strings_sent   = 0;
    int   n_v4 = 0, n_v6 = 0, n_mcast = 0, n_reject = 0;

    ip_address_text_validator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Address parse predictor
    // ------------------------------------------------------------------
    function automatic void clear_scan();
        scan       = '0;
        scan.v4_ok = 1'b1;
        scan.v6_ok = 1'b1;
    endfunction

    function automatic void close_v6_group();
        if (scan.v6_digits != 0 && scan.v6_groups != 4'd15)
            scan.v6_groups = scan.v6_groups + 1'b1;
        scan.v6_digits = '0;
    endfunction

    // Feeds one character; returns 1 with the verdict when it closes the string.
    function automatic bit advance_scan(input logic [7:0] c, input logic last,
                                        output t_verdict v);
        logic [3:0] d;
        bit         is_dec;
        bit         is_hex;
        bit         v4;
        bit         v6;
        is_dec = c inside {[CHAR_0:CHAR_9]};
        is_hex = c inside {[CHAR_0:CHAR_9], [CHAR_LA:CHAR_LF], [CHAR_UA:CHAR_UF]};
        d      = 4'(c - CHAR_0);
        v      = '0;

        if (scan.chars < CNT_SAT) scan.chars = scan.chars + 1'b1;
        if (scan.chars > V4_MAX_LEN) scan.v4_ok = 1'b0;
        if (scan.chars > V6_MAX_LEN) scan.v6_ok = 1'b0;

        // dotted quad
        if (is_dec) begin
            if (scan.v4_digits == 2'd3) begin
                scan.v4_ok = 1'b0;
            end else if (scan.v4_digits != 0 && scan.v4_lead0) begin
                scan.v4_ok = 1'b0;
            end else begin
                if (scan.v4_digits == 0) scan.v4_lead0 = (d == 0);
                scan.v4_value  = 10'(scan.v4_value * 10 + d);
                scan.v4_digits = scan.v4_digits + 1'b1;
                if (scan.v4_value > OCTET_MAX) scan.v4_ok = 1'b0;
            end
        end else if (c == CHAR_DOT) begin
            if (scan.v4_digits == 0 || scan.v4_dots >= 3'd3) begin
                scan.v4_ok = 1'b0;
            end else begin
                if (scan.v4_dots == 0) scan.v4_first = scan.v4_value[7:0];
                scan.v4_dots   = scan.v4_dots + 1'b1;
                scan.v4_digits = '0;
                scan.v4_value  = '0;
                scan.v4_lead0  = 1'b0;
            end
        end else begin
            scan.v4_ok = 1'b0;
        end

        // colon-hex text
        if (is_hex) begin
            // a single colon at the very start is not allowed
            if (scan.v6_run_start && scan.v6_run == 2'd1) scan.v6_ok = 1'b0;
            scan.v6_run       = '0;
            scan.v6_run_start = 1'b0;
            if (scan.v6_digits < 3'd5) scan.v6_digits = scan.v6_digits + 1'b1;
            if (scan.v6_digits > 3'd4) scan.v6_ok = 1'b0;
        end else if (c == CHAR_COLON) begin
            close_v6_group();
            if (scan.chars == 6'd1) scan.v6_run_start = 1'b1;
            if (scan.v6_run < 2'd3) scan.v6_run = scan.v6_run + 1'b1;
            if (scan.v6_run == 2'd2) begin
                if (scan.v6_compress) scan.v6_ok = 1'b0;
                scan.v6_compress = 1'b1;
            end else if (scan.v6_run == 2'd3) begin
                scan.v6_ok = 1'b0;
            end
        end else begin
            scan.v6_ok = 1'b0;
        end

        if (!last) return 1'b0;

        v4 = scan.v4_ok && scan.v4_dots == 3'd3 && scan.v4_digits != 0;
        if (scan.v6_run == 2'd1) scan.v6_ok = 1'b0;   // lone trailing colon
        close_v6_group();
        v6 = scan.v6_ok && (scan.v6_compress ? scan.v6_groups <= 4'd7
                                             : scan.v6_groups == 4'd8);
        v.valid_ipv4   = v4;
        v.valid_ipv6   = v6;
        v.valid_any    = v4 || v6;
        v.multicast_v4 = v4 && (scan.v4_first inside {[MCAST_LO:MCAST_HI]});

        n_v4     += v4;
        n_v6     += v6;
        n_mcast  += v.multicast_v4;
        n_reject += !(v4 || v6);
        clear_scan();
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [3:0] want,
                                        input logic [3:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Address text generators; all build into `text`
    // ------------------------------------------------------------------
    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    endtask

    function automatic logic [7:0] hex_char(input int unsigned v);
        if (v < 10) return 8'(CHAR_0 + v);
        return 8'(($urandom_range(0, 1) ? CHAR_UA : CHAR_LA) + v - 10);
    endfunction

    // near-miss and random bytes for mutations and noise
    function automatic logic [7:0] pick_char();
        logic [7:0] odd[7] = '{8'h2F, 8'h40, 8'h47, 8'h67, 8'h60, 8'h3B, 8'h2D};
        case ($urandom_range(0, 7))
            0:       return 8'(CHAR_0 + $urandom_range(0, 9));
            1:       return 8'(CHAR_LA + $urandom_range(0, 5));
            2:       return 8'(CHAR_UA + $urandom_range(0, 5));
            3:       return CHAR_DOT;
            4:       return CHAR_COLON;
            5:       return odd[$urandom_range(0, 6)];
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // full: every octet three digits (15 chars); loose: octets up to 999, stray zeros
    task automatic add_ipv4(input bit full, input bit loose);
        int unsigned octet;
        for (int i = 0; i < 4; i++) begin
            if (i > 0) text.push_back(CHAR_DOT);
            if (full)
                octet = $urandom_range(100, 255);
            else if (loose)
                octet = $urandom_range(0, 999);
            else if (i == 0 && $urandom_range(0, 3) == 0)
                octet = $urandom_range(220, 243);     // around the multicast range
            else
                octet = $urandom_range(0, 255);
            if (loose && $urandom_range(0, 5) == 0) text.push_back(CHAR_0);
            add_str($sformatf("%0d", octet));
        end
    endtask

    // full: eight groups of four digits (39 chars); else maybe a "::" somewhere
    task automatic add_ipv6(input bit full);
        bit squeeze;
        int groups;
        int split;
        int digits;
        squeeze = !full && $urandom_range(0, 1);
        groups  = squeeze ? $urandom_range(0, 7) : 8;
        split   = $urandom_range(0, groups);
        for (int i = 0; i < groups; i++) begin
            if (squeeze && i == split)
                add_str("::");
            else if (i > 0)
                text.push_back(CHAR_COLON);
            digits = full ? 4 : $urandom_range(1, 4);
            repeat (digits) text.push_back(hex_char($urandom_range(0, 15)));
        end
        if (squeeze && split == groups) add_str("::");
    endtask

    task automatic mutate_text();
        int pos;
        repeat ($urandom_range(1, 2)) begin
            pos = $urandom_range(0, text.size() - 1);
            case ($urandom_range(0, 2))
                0: text[pos] = pick_char();
                1: text.insert(pos, pick_char());
                default: if (text.size() > 1) text.delete(pos);
            endcase
        end
    endtask

    task automatic send_text();
        t_char_xfer x;
        for (int i = 0; i < text.size(); i++) begin
            x.ch   = text[i];
            x.last = (i == text.size() - 1);
            chars_pending.push_back(x);
        end
        chars_queued += text.size();
        strings_sent++;
        text.delete();
    endtask

    task automatic send_str(input string s);
        add_str(s);
        send_text();
    endtask

    // one random string, mostly well formed
    task automatic make_random_text();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            add_ipv4(1'b0, 1'b0);
        end else if (pick < 30) begin
            add_ipv4(1'b1, 1'b0);
        end else if (pick < 52) begin
            add_ipv6(1'b0);
        end else if (pick < 57) begin
            add_ipv6(1'b1);
        end else if (pick < 82) begin
            case ($urandom_range(0, 3))
                0: add_ipv4(1'b0, 1'b0);
                1: add_ipv4(1'b0, 1'b1);
                2: add_ipv4(1'b1, 1'b0);
                default: add_ipv6($urandom_range(0, 3) == 0);
            endcase
            if (pick < 79) mutate_text();   // a few of these strings stay untouched
        end else if (pick < 95) begin
            repeat ($urandom_range(1, 12)) text.push_back(pick_char());
        end else begin
            // long strings, which can run past both length limits and the counter's saturation point
            repeat ($urandom_range(36, 60)) text.push_back(pick_char());
        end
    endtask

    // Sender stops until every character is in and every verdict is out.
    task automatic wait_all_verdicts();
        @(negedge i_clk);
        while (chars_accepted != chars_queued || verdicts_due.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic bit calm();
        return cycles >= CALM_FROM && cycles < CALM_TO;
    endfunction

    // ------------------------------------------------------------------
    // Driver: slave side, changes at the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : driver
        t_char_xfer x;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_accepted) begin
            if (chars_pending.size() != 0 && (calm() || $urandom_range(0, 99) >= IDLE_PCT)) begin
                x = chars_pending.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= x.ch;
                s_axis_tlast  <= x.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // master side back-pressure
    always @(negedge i_clk) begin : sink
        m_axis_tready <= i_rst_n && (calm() || $urandom_range(0, 99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Monitor: samples both sides at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_verdict want;
        t_verdict got;
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            in_accepted <= 1'b0;
        end else begin
            in_accepted <= s_axis_tvalid && s_axis_tready;
            // check first: a verdict never leaves on the edge its tlast arrives
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdicts_due.size() == 0) begin
                    $error("unexpected verdict transfer, tdata %h", m_axis_tdata);
                    errors++;
                end else begin
                    want = verdicts_due.pop_front();
                    got  = t_verdict'(m_axis_tdata[3:0]);
                    check_field("valid_ipv4", want.valid_ipv4, got.valid_ipv4);
                    check_field("valid_ipv6", want.valid_ipv6, got.valid_ipv6);
                    check_field("valid_any", want.valid_any, got.valid_any);
                    check_field("multicast_v4", want.multicast_v4, got.multicast_v4);
                    check_field("tdata pad", 4'h0, m_axis_tdata[7:4]);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                chars_accepted++;
                if (advance_scan(s_axis_tdata, s_axis_tlast, want))
                    verdicts_due.push_back(want);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int random_base;
        clear_scan();

        // directed: multicast low edge with a 255 octet, bare "::",
        // mixed-case compressed group, a top-bit byte alone, lone colon
        // at either end, and a NUL byte at the start of a string
        send_str("224.0.0.255");
        send_str("::");
        send_str("::Ab9");
        text.push_back(8'hFF);
        send_text();
        send_str(":1");
        send_str("1:");
        text.push_back(8'h00);
        add_str("1");
        send_text();

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // hold the sender back until the pipe is fully drained
        wait_all_verdicts();
        @(posedge i_clk);
        random_base = chars_queued;
        while (chars_queued - random_base < RANDOM_CHARS / 2) begin
            make_random_text();
            send_text();
        end

        wait_all_verdicts();
        @(posedge i_clk);
        while (chars_queued - random_base < RANDOM_CHARS) begin
            make_random_text();
            send_text();
        end

        wait_all_verdicts();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Run covered %0d characters in %0d address strings.",
                 chars_accepted, strings_sent);
        $display("Verdicts: %0d IPv4 valid (%0d multicast), %0d IPv6 valid, %0d rejected.",
                 n_v4, n_mcast, n_v6, n_reject);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/ipatv_pkg.sv
sv/ip_address_text_validator.sv
tb/sv/testbench.sv
